// File: src/nibble_serial_mouse_port_macros.svh
// Assertion macros for the nibble serial mouse port.
// Used by the top level; the checks name aclk and aresetn of the including module.
`ifndef NIBBLE_SERIAL_MOUSE_PORT_MACROS_SVH
`define NIBBLE_SERIAL_MOUSE_PORT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define NSMP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`define NSMP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define NSMP_ASSERT_SAME(lbl, ante, cons, msg)
`define NSMP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: src/nsmp_pkg.sv
// Package for the nibble serial mouse port: widths, codes, beat types and helpers.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package nsmp_pkg;

    localparam int ACCUM_WIDTH = 16;
    localparam int SUM_W       = ACCUM_WIDTH + 1;
    localparam int SCALE_W     = 8;
    localparam int DIVIDEND_W  = ACCUM_WIDTH + SCALE_W;
    localparam int DIVISOR_W   = 16;
    localparam int GAP_W       = 10;
    localparam int DIV_STEPS   = DIVIDEND_W;
    localparam int STEP_CNT_W  = $clog2(DIV_STEPS);
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 2;

    localparam logic [SCALE_W-1:0]   SCALE_NUM   = 8'd200;
    localparam logic [GAP_W-1:0]     GAP_MAX     = 10'h3ff;
    localparam logic [DIVISOR_W-1:0] DPI_RESET   = 16'd200;
    localparam logic [GAP_W-1:0]     TIMEOUT_RESET = 10'd300;
    localparam logic [3:0]           PINS_RESET  = 4'hf;

    localparam logic [1:0] OP_REPORT = 2'd0;
    localparam logic [1:0] OP_STROBE = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_DPI     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE = 2'd2;

    typedef struct packed {
        logic [1:0]        opcode;
        logic signed [7:0] delta_x;
        logic signed [7:0] delta_y;
        logic [7:0]        buttons;
        logic              falling_edge;
    } in_beat_t;

    typedef struct packed {
        logic [3:0] data_pins;
        logic       trigger_left;
        logic       trigger_right;
    } out_beat_t;

    typedef struct packed {
        logic accept;
        logic div_load;
        logic div_step;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic frame_start;
        logic res_full;
    } ctrl_stat_t;

    function automatic logic [ACCUM_WIDTH-1:0] sat_add(input logic [ACCUM_WIDTH-1:0] acc,
                                                       input logic signed [7:0] delta);
        logic [SUM_W-1:0] sum;
        logic [ACCUM_WIDTH-1:0] r;
        sum = {acc[ACCUM_WIDTH-1], acc} + SUM_W'(delta);
        if (sum[SUM_W-1] != sum[SUM_W-2]) begin
            r = sum[SUM_W-1] ? {1'b1, {(ACCUM_WIDTH-1){1'b0}}}
                             : {1'b0, {(ACCUM_WIDTH-1){1'b1}}};
        end else begin
            r = sum[ACCUM_WIDTH-1:0];
        end
        return r;
    endfunction

    function automatic logic [7:0] clamp_axis(input logic [DIVIDEND_W-1:0] q,
                                              input logic neg);
        logic [7:0] r;
        if (!neg) begin
            r = (q > DIVIDEND_W'(127)) ? 8'h7f : q[7:0];
        end else begin
            r = (q > DIVIDEND_W'(128)) ? 8'h80 : 8'(~q[7:0] + 8'd1);
        end
        return r;
    endfunction

    function automatic logic [3:0] nib_to_pins(input logic [3:0] nib, input logic rev);
        logic [3:0] n;
        n = rev ? {nib[0], nib[1], nib[2], nib[3]} : nib;
        return ~n;
    endfunction

endpackage

// File: src/nsmp_div.sv
// Restoring divider datapath, one quotient bit per step command.
// Depends on nsmp_pkg; the step count is kept by the controller.
`timescale 1ns / 1ps

module nsmp_div (
    input  logic                             aclk,
    input  logic                             load,
    input  logic                             step,
    input  logic [nsmp_pkg::DIVIDEND_W-1:0]  dividend,
    input  logic [nsmp_pkg::DIVISOR_W-1:0]   divisor,
    output logic [nsmp_pkg::DIVIDEND_W-1:0]  quotient
);

    logic [nsmp_pkg::DIVISOR_W-1:0]  div_reg;
    logic [nsmp_pkg::DIVISOR_W-1:0]  rem_reg;
    logic [nsmp_pkg::DIVISOR_W-1:0]  rem_next;
    logic [nsmp_pkg::DIVIDEND_W-1:0] quo_reg;
    logic [nsmp_pkg::DIVIDEND_W-1:0] quo_next;
    logic [nsmp_pkg::DIVISOR_W:0]    shifted;
    logic [nsmp_pkg::DIVISOR_W:0]    diff;
    logic                            ge;

    always_comb begin
        shifted  = {rem_reg, quo_reg[nsmp_pkg::DIVIDEND_W-1]};
        diff     = shifted - {1'b0, div_reg};
        ge       = shifted >= {1'b0, div_reg};
        rem_next = ge ? diff[nsmp_pkg::DIVISOR_W-1:0] : shifted[nsmp_pkg::DIVISOR_W-1:0];
        quo_next = {quo_reg[nsmp_pkg::DIVIDEND_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            div_reg <= (divisor == '0) ? nsmp_pkg::DIVISOR_W'(1) : divisor;
            rem_reg <= '0;
            quo_reg <= dividend;
        end else if (step) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign quotient = quo_reg;

endmodule

// File: src/nsmp_ctrl.sv
// Controller state machine: accepts beats, sequences the division and the frame update.
// Depends on nsmp_pkg for the command and status types.
`timescale 1ns / 1ps

module nsmp_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  nsmp_pkg::ctrl_stat_t stat,
    output nsmp_pkg::ctrl_cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]                       state_reg;
    logic [1:0]                       state_next;
    logic [nsmp_pkg::STEP_CNT_W-1:0]  cnt_reg;
    logic [nsmp_pkg::STEP_CNT_W-1:0]  cnt_next;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = !stat.res_full;
                if (s_valid && !stat.res_full) begin
                    cmd.accept = 1'b1;
                    if (stat.frame_start) begin
                        cmd.div_load = 1'b1;
                        cnt_next     = '0;
                        state_next   = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == nsmp_pkg::STEP_CNT_W'(nsmp_pkg::DIV_STEPS - 1)) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// File: src/nsmp_datapath.sv
// Datapath: configuration, accumulators, frame and pin state, dividers, result stages.
// Depends on nsmp_pkg and nsmp_div; driven by commands from nsmp_ctrl.
`timescale 1ns / 1ps

module nsmp_datapath (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  nsmp_pkg::in_beat_t                 s_data,
    input  nsmp_pkg::ctrl_cmd_t                cmd,
    output nsmp_pkg::ctrl_stat_t               stat,
    input  logic                               cfg_wr_en,
    input  logic [nsmp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [nsmp_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output logic                               m_valid,
    input  logic                               m_ready,
    output nsmp_pkg::out_beat_t                m_data
);

    logic [nsmp_pkg::DIVISOR_W-1:0]   dpi_reg;
    logic [nsmp_pkg::GAP_W-1:0]       timeout_reg;
    logic                             reverse_reg;
    logic [nsmp_pkg::ACCUM_WIDTH-1:0] accx_reg;
    logic [nsmp_pkg::ACCUM_WIDTH-1:0] accy_reg;
    logic [15:0]                      frame_reg;
    logic [1:0]                       idx_reg;
    logic [nsmp_pkg::GAP_W-1:0]       gap_reg;
    logic [3:0]                       pins_reg;
    logic [1:0]                       btn_reg;
    logic                             negx_reg;
    logic                             negy_reg;
    logic                             res_valid_reg;
    nsmp_pkg::out_beat_t              res_reg;
    logic                             out_valid_reg;
    nsmp_pkg::out_beat_t              out_reg;

    logic                             restart;
    logic [1:0]                       eff_idx;
    logic [3:0]                       pins_strobe;
    logic [15:0]                      frame_new;
    logic [3:0]                       pins_frame;
    logic [nsmp_pkg::ACCUM_WIDTH-1:0] absx;
    logic [nsmp_pkg::ACCUM_WIDTH-1:0] absy;
    logic [nsmp_pkg::DIVIDEND_W-1:0]  magx;
    logic [nsmp_pkg::DIVIDEND_W-1:0]  magy;
    logic [nsmp_pkg::DIVIDEND_W-1:0]  quox;
    logic [nsmp_pkg::DIVIDEND_W-1:0]  quoy;
    logic [nsmp_pkg::ACCUM_WIDTH-1:0] sumx;
    logic [nsmp_pkg::ACCUM_WIDTH-1:0] sumy;

    always_comb begin
        restart     = s_data.falling_edge && (gap_reg >= timeout_reg);
        eff_idx     = restart ? 2'd0 : idx_reg;
        pins_strobe = nsmp_pkg::nib_to_pins(frame_reg[{~eff_idx, 2'b00} +: 4], reverse_reg);
        frame_new   = {nsmp_pkg::clamp_axis(quox, negx_reg),
                       nsmp_pkg::clamp_axis(quoy, negy_reg)};
        pins_frame  = nsmp_pkg::nib_to_pins(frame_new[15:12], reverse_reg);
        absx        = accx_reg[nsmp_pkg::ACCUM_WIDTH-1] ? (~accx_reg + 1'b1) : accx_reg;
        absy        = accy_reg[nsmp_pkg::ACCUM_WIDTH-1] ? (~accy_reg + 1'b1) : accy_reg;
        magx        = nsmp_pkg::DIVIDEND_W'(absx) * nsmp_pkg::DIVIDEND_W'(nsmp_pkg::SCALE_NUM);
        magy        = nsmp_pkg::DIVIDEND_W'(absy) * nsmp_pkg::DIVIDEND_W'(nsmp_pkg::SCALE_NUM);
        sumx        = nsmp_pkg::sat_add(accx_reg, s_data.delta_x);
        sumy        = nsmp_pkg::sat_add(accy_reg, s_data.delta_y);
        stat.frame_start = (s_data.opcode == nsmp_pkg::OP_STROBE) && (eff_idx == 2'd0);
        stat.res_full    = res_valid_reg;
    end

    nsmp_div u_div_x (
        .aclk     (aclk),
        .load     (cmd.div_load),
        .step     (cmd.div_step),
        .dividend (magx),
        .divisor  (dpi_reg),
        .quotient (quox)
    );

    nsmp_div u_div_y (
        .aclk     (aclk),
        .load     (cmd.div_load),
        .step     (cmd.div_step),
        .dividend (magy),
        .divisor  (dpi_reg),
        .quotient (quoy)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dpi_reg       <= nsmp_pkg::DPI_RESET;
            timeout_reg   <= nsmp_pkg::TIMEOUT_RESET;
            reverse_reg   <= 1'b0;
            accx_reg      <= '0;
            accy_reg      <= '0;
            frame_reg     <= '0;
            idx_reg       <= '0;
            gap_reg       <= '0;
            pins_reg      <= nsmp_pkg::PINS_RESET;
            btn_reg       <= '0;
            negx_reg      <= 1'b0;
            negy_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    nsmp_pkg::CFG_DPI:     dpi_reg     <= cfg_wdata;
                    nsmp_pkg::CFG_TIMEOUT: timeout_reg <= cfg_wdata[nsmp_pkg::GAP_W-1:0];
                    nsmp_pkg::CFG_REVERSE: reverse_reg <= cfg_wdata[0];
                    default: begin
                    end
                endcase
            end

            if (res_valid_reg && (!out_valid_reg || m_ready)) begin
                out_reg       <= res_reg;
                out_valid_reg <= 1'b1;
                res_valid_reg <= 1'b0;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end

            if (cmd.accept) begin
                unique case (s_data.opcode)
                    nsmp_pkg::OP_REPORT: begin
                        btn_reg               <= s_data.buttons[1:0];
                        accx_reg              <= sumx;
                        accy_reg              <= sumy;
                        res_reg.data_pins     <= pins_reg;
                        res_reg.trigger_left  <= s_data.buttons[0];
                        res_reg.trigger_right <= s_data.buttons[1];
                        res_valid_reg         <= 1'b1;
                    end
                    nsmp_pkg::OP_STROBE: begin
                        gap_reg <= '0;
                        idx_reg <= eff_idx + 2'd1;
                        if (stat.frame_start) begin
                            negx_reg <= !accx_reg[nsmp_pkg::ACCUM_WIDTH-1];
                            negy_reg <= !accy_reg[nsmp_pkg::ACCUM_WIDTH-1];
                            accx_reg <= '0;
                            accy_reg <= '0;
                        end else begin
                            pins_reg              <= pins_strobe;
                            res_reg.data_pins     <= pins_strobe;
                            res_reg.trigger_left  <= btn_reg[0];
                            res_reg.trigger_right <= btn_reg[1];
                            res_valid_reg         <= 1'b1;
                        end
                    end
                    nsmp_pkg::OP_TICK: begin
                        if (gap_reg != nsmp_pkg::GAP_MAX) begin
                            gap_reg <= gap_reg + 1'b1;
                        end
                        res_reg.data_pins     <= pins_reg;
                        res_reg.trigger_left  <= btn_reg[0];
                        res_reg.trigger_right <= btn_reg[1];
                        res_valid_reg         <= 1'b1;
                    end
                    nsmp_pkg::OP_NONE: begin
                        res_reg.data_pins     <= pins_reg;
                        res_reg.trigger_left  <= btn_reg[0];
                        res_reg.trigger_right <= btn_reg[1];
                        res_valid_reg         <= 1'b1;
                    end
                    default: begin
                    end
                endcase
            end

            if (cmd.finish) begin
                frame_reg             <= frame_new;
                pins_reg              <= pins_frame;
                res_reg.data_pins     <= pins_frame;
                res_reg.trigger_left  <= btn_reg[0];
                res_reg.trigger_right <= btn_reg[1];
                res_valid_reg         <= 1'b1;
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

// File: src/nibble_serial_mouse_port.sv
// Channel   Ports                          Content
// input     s_valid, s_ready, s_data       report, strobe edge, tick or none beat
// result    m_valid, m_ready, m_data       pin levels and button lines
// config    cfg_wr_en, cfg_index, cfg_wdata  dpi_divisor, timeout_us, reverse_nibble
//
// Reports, ticks and in-frame strobes each yield one result; a full result stage stalls input.
// A frame-start strobe blocks input while two 24-step restoring dividers run in parallel.
// Reset clears all but the divider registers synchronously; no clearing pass is needed.
// A result waiting at the output does not block the next beat, which fills the result stage.
// Top level of the nibble serial mouse port; depends on nsmp_pkg, nsmp_ctrl, nsmp_datapath.
`timescale 1ns / 1ps
`include "nibble_serial_mouse_port_macros.svh"

module nibble_serial_mouse_port (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  nsmp_pkg::in_beat_t               s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output nsmp_pkg::out_beat_t              m_data,
    input  logic                             cfg_wr_en,
    input  logic [nsmp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [nsmp_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    nsmp_pkg::ctrl_cmd_t  cmd;
    nsmp_pkg::ctrl_stat_t stat;

    nsmp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    nsmp_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    `NSMP_ASSERT_NEXT(a_frame_busy, s_valid && s_ready && stat.frame_start, !s_ready, "frame start did not block input")
    `NSMP_ASSERT_NEXT(a_simple_result, s_valid && s_ready && !stat.frame_start, stat.res_full, "beat produced no result")
    `NSMP_ASSERT_NEXT(a_finish_result, cmd.finish, stat.res_full && !cmd.finish, "frame finish produced no result")

endmodule

// File: tb/mouse_port_checker.sv
// Checker for the nibble serial mouse port: tracks register writes, predicts the pin
// and button levels of every accepted beat and compares them with the result beats.
// Depends on nsmp_pkg for the beat types, opcodes and register indexes.
`timescale 1ns / 1ps

module mouse_port_checker
    import nsmp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  in_beat_t              s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  out_beat_t             m_data,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                    failures,
    output int                    levels_pending
);

    logic [15:0]                   dpi_reg;
    logic [GAP_W-1:0]              timeout_reg;
    logic                          reverse_reg;

    logic signed [ACCUM_WIDTH-1:0] move_x;
    logic signed [ACCUM_WIDTH-1:0] move_y;
    logic [15:0]                   frame_bits;
    logic [1:0]                    nibble_pos;
    logic [GAP_W-1:0]              idle_ticks;
    logic [3:0]                    pin_state;
    logic [1:0]                    button_state;

    out_beat_t expected_levels[$];
    int        failure_total = 0;
    int        failures_q = 0;
    int        pending_q = 0;

    assign failures       = failures_q;
    assign levels_pending = pending_q;

    function automatic logic signed [ACCUM_WIDTH-1:0] clamp_sum(
        input logic signed [ACCUM_WIDTH-1:0] acc, input logic signed [7:0] delta);
        longint sum;
        longint top;
        top = (longint'(1) <<< (ACCUM_WIDTH - 1)) - 1;
        sum = longint'(acc) + longint'(delta);
        if (sum > top) sum = top;
        if (sum < -top - 1) sum = -top - 1;
        return ACCUM_WIDTH'(sum);
    endfunction

    function automatic logic [7:0] scaled_axis(input logic signed [ACCUM_WIDTH-1:0] acc);
        longint divisor;
        longint q;
        divisor = (dpi_reg == 16'd0) ? 1 : longint'(dpi_reg);
        q = (-longint'(acc) * 200) / divisor;
        if (q > 127) q = 127;
        if (q < -128) q = -128;
        return 8'(q);
    endfunction

    task automatic drive_strobe(input logic falling);
        logic [3:0] nib;
        if (falling && idle_ticks >= timeout_reg) nibble_pos = 2'd0;
        idle_ticks = '0;
        if (nibble_pos == 2'd0) begin
            frame_bits = {scaled_axis(move_x), scaled_axis(move_y)};
            move_x = '0;
            move_y = '0;
        end
        case (nibble_pos)
            2'd0: nib = frame_bits[15:12];
            2'd1: nib = frame_bits[11:8];
            2'd2: nib = frame_bits[7:4];
            default: nib = frame_bits[3:0];
        endcase
        if (reverse_reg) nib = {nib[0], nib[1], nib[2], nib[3]};
        pin_state = ~nib;
        nibble_pos = nibble_pos + 2'd1;
    endtask

    task automatic advance_port_state(input in_beat_t b);
        out_beat_t lv;
        case (b.opcode)
            OP_REPORT: begin
                button_state = b.buttons[1:0];
                move_x = clamp_sum(move_x, b.delta_x);
                move_y = clamp_sum(move_y, b.delta_y);
            end
            OP_STROBE: drive_strobe(b.falling_edge);
            OP_TICK: begin
                if (idle_ticks != GAP_MAX) idle_ticks = idle_ticks + 1'b1;
            end
            default: ;
        endcase
        lv.data_pins     = pin_state;
        lv.trigger_left  = button_state[0];
        lv.trigger_right = button_state[1];
        expected_levels.push_back(lv);
    endtask

    always @(posedge aclk) begin : watch
        out_beat_t want;
        if (!aresetn) begin
            dpi_reg      = DPI_RESET;
            timeout_reg  = TIMEOUT_RESET;
            reverse_reg  = 1'b0;
            move_x       = '0;
            move_y       = '0;
            frame_bits   = '0;
            nibble_pos   = '0;
            idle_ticks   = '0;
            pin_state    = PINS_RESET;
            button_state = '0;
            expected_levels.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_DPI:     dpi_reg = cfg_wdata;
                    CFG_TIMEOUT: timeout_reg = cfg_wdata[GAP_W-1:0];
                    CFG_REVERSE: reverse_reg = cfg_wdata[0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (expected_levels.size() == 0) begin
                    $error("result beat %h arrived with nothing outstanding", m_data);
                    failure_total++;
                end else begin
                    want = expected_levels.pop_front();
                    if (m_data.data_pins !== want.data_pins) begin
                        $error("data_pins expected %h actual %h",
                               want.data_pins, m_data.data_pins);
                        failure_total++;
                    end
                    if (m_data.trigger_left !== want.trigger_left) begin
                        $error("trigger_left expected %b actual %b",
                               want.trigger_left, m_data.trigger_left);
                        failure_total++;
                    end
                    if (m_data.trigger_right !== want.trigger_right) begin
                        $error("trigger_right expected %b actual %b",
                               want.trigger_right, m_data.trigger_right);
                        failure_total++;
                    end
                end
            end
            if (s_valid && s_ready) advance_port_state(s_data);
        end
        failures_q <= failure_total;
        pending_q  <= expected_levels.size();
    end

endmodule

// File: tb/nibble_serial_mouse_port_tb.sv
// Top of the nibble serial mouse port testbench: clock, reset, register setup,
// report, strobe and tick stimulus with random stalls, and the final verdict.
// Depends on nsmp_pkg, nibble_serial_mouse_port and mouse_port_checker.
`timescale 1ns / 1ps

module nibble_serial_mouse_port_tb;
    import nsmp_pkg::*;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 40;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_beat_t              s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_beat_t             m_data;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int failures;
    int levels_pending;
    int cycles = 0;
    int items_sent = 0;
    int cur_timeout = 300;
    bit steady = 1'b0;
    bit hold_request = 1'b0;

    nibble_serial_mouse_port dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    mouse_port_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .failures       (failures),
        .levels_pending (levels_pending)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic in_beat_t make_beat(input logic [1:0] op, input logic [7:0] dx,
                                           input logic [7:0] dy, input logic [7:0] btn,
                                           input logic fe);
        in_beat_t b;
        b.opcode       = op;
        b.delta_x      = dx;
        b.delta_y      = dy;
        b.buttons      = btn;
        b.falling_edge = fe;
        return b;
    endfunction

    task automatic offer(input in_beat_t b);
        if (!steady && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic send_op(input logic [1:0] op, input logic fe);
        offer(make_beat(op, 8'($urandom), 8'($urandom), 8'($urandom), fe));
    endtask

    task automatic quiesce();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (levels_pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic reconfigure(input logic [15:0] dpi, input int tmo, input logic rev);
        quiesce();
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_DPI;
        cfg_wdata <= dpi;
        @(posedge aclk);
        cfg_index <= CFG_TIMEOUT;
        cfg_wdata <= 16'(tmo);
        @(posedge aclk);
        cfg_index <= CFG_REVERSE;
        cfg_wdata <= {15'd0, rev};
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cur_timeout = tmo;
    endtask

    task automatic frame_sequence();
        int run;
        repeat ($urandom_range(0, 4)) send_op(OP_REPORT, 1'($urandom));
        if (cur_timeout <= 64)
            run = $urandom_range(cur_timeout + 2, (cur_timeout > 2) ? cur_timeout - 2 : 0);
        else
            run = $urandom_range(0, 6);
        repeat (run) send_op(OP_TICK, 1'($urandom));
        for (int k = 0; k < 4; k++) begin
            send_op(OP_STROBE, (k % 2) == 0);
            repeat ($urandom_range(0, 2))
                send_op(($urandom_range(0, 2) == 0) ? OP_REPORT : OP_TICK, 1'($urandom));
        end
    endtask

    task automatic random_phase(input int target);
        int start;
        start = items_sent;
        while (items_sent - start < target) begin
            if ($urandom_range(0, 9) < 6)
                frame_sequence();
            else
                repeat ($urandom_range(1, 3))
                    offer(make_beat(2'($urandom), 8'($urandom), 8'($urandom),
                                    8'($urandom), 1'($urandom)));
        end
    endtask

    initial begin : result_sink
        wait (aresetn === 1'b1);
        forever begin
            if (hold_request) begin
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
                hold_request = 1'b0;
            end else if (!steady && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge aclk);
            end
        end
    end

    initial begin : stimulus
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        offer(make_beat(OP_NONE, 8'h5a, 8'ha5, 8'h3c, 1'b1));
        offer(make_beat(OP_REPORT, 8'h7f, 8'h80, 8'hff, 1'b0));
        offer(make_beat(OP_REPORT, 8'h80, 8'h7f, 8'h01, 1'b1));
        offer(make_beat(OP_REPORT, 8'h00, 8'h00, 8'h02, 1'b0));
        offer(make_beat(OP_TICK, 8'hff, 8'hff, 8'hff, 1'b1));
        offer(make_beat(OP_STROBE, 8'h00, 8'h00, 8'h00, 1'b0));
        offer(make_beat(OP_STROBE, 8'h7f, 8'h80, 8'hff, 1'b1));
        offer(make_beat(OP_STROBE, 8'h00, 8'h00, 8'h00, 1'b0));
        offer(make_beat(OP_STROBE, 8'h00, 8'h00, 8'h00, 1'b1));
        offer(make_beat(OP_REPORT, 8'hf6, 8'h14, 8'hfc, 1'b1));
        offer(make_beat(OP_STROBE, 8'hff, 8'hff, 8'hff, 1'b1));
        offer(make_beat(OP_TICK, 8'h00, 8'h00, 8'h00, 1'b0));
        offer(make_beat(OP_STROBE, 8'h80, 8'h7f, 8'h03, 1'b0));
        offer(make_beat(OP_NONE, 8'hff, 8'hff, 8'hff, 1'b1));
        offer(make_beat(OP_NONE, 8'h00, 8'h00, 8'h00, 1'b0));

        reconfigure(16'd1, 1, 1'b0);
        repeat (260) offer(make_beat(OP_REPORT, 8'h7f, 8'h80, 8'($urandom), 1'($urandom)));
        send_op(OP_TICK, 1'b0);
        send_op(OP_STROBE, 1'b1);
        random_phase(80);

        reconfigure(16'd65535, 1023, 1'b1);
        repeat (40) offer(make_beat(OP_REPORT, 8'h80, 8'h7f, 8'($urandom), 1'($urandom)));
        repeat (40) send_op(OP_TICK, 1'($urandom));
        send_op(OP_STROBE, 1'b1);
        send_op(OP_STROBE, 1'b0);
        hold_request = 1'b1;
        random_phase(80);

        reconfigure(16'd0, 3, 1'b1);
        random_phase(80);

        reconfigure(16'd200, 12, 1'b0);
        random_phase(80);

        reconfigure(16'($urandom_range(1, 1000)), $urandom_range(1, 40), 1'($urandom));
        random_phase(80);

        reconfigure(16'd137, 7, 1'b1);
        steady = 1'b1;
        random_phase(80);

        quiesce();
        if (failures == 0 && levels_pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: files.f
+incdir+src
src/nsmp_pkg.sv
src/nsmp_div.sv
src/nsmp_ctrl.sv
src/nsmp_datapath.sv
src/nibble_serial_mouse_port.sv
tb/mouse_port_checker.sv
tb/nibble_serial_mouse_port_tb.sv
